>>> rtl/plt_pkg.sv
// shared types, codes and defaults of the piecewise linear track table
// used by the stream interfaces, the divider, the multiplier and the top level
package plt_pkg;

    localparam int NUM_CH          = 5;
    localparam int DEF_MAX_POINTS  = 1024;
    localparam int DEF_FRAC_BITS   = 16;
    localparam int SEG_W           = 10;
    localparam int TERM_W          = 42;

    localparam logic [1:0] K_APPEND = 2'd0;
    localparam logic [1:0] K_QUERY  = 2'd1;
    localparam logic [1:0] K_CLEAR  = 2'd2;
    localparam logic [1:0] K_UNUSED = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NONMONO = 3'd1;
    localparam logic [2:0] ST_WIDTH   = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_BELOW   = 3'd4;
    localparam logic [2:0] ST_ABOVE   = 3'd5;
    localparam logic [2:0] ST_FEW     = 3'd6;

    typedef logic signed [31:0] t_val;
    typedef logic [NUM_CH-1:0][31:0] t_vals;

    typedef struct packed {
        logic               start;
        logic signed [32:0] dv;
        logic [31:0]        ds;
    } t_div_req;

    typedef struct packed {
        logic               start;
        logic signed [63:0] slope;
        logic signed [32:0] span;
    } t_mul_req;

endpackage

>>> rtl/plt_stream_if.sv
// valid/ready stream interfaces for breakpoint/query words and result words
// depends on plt_pkg
interface plt_pt_if;
    import plt_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    t_val       position;
    t_val       x_value;
    t_val       y_value;
    t_val       heading_value;
    t_val       curvature_value;
    t_val       width_value;

    modport source (output valid, kind, position, x_value, y_value, heading_value,
                    curvature_value, width_value, input ready);
    modport sink (input valid, kind, position, x_value, y_value, heading_value,
                  curvature_value, width_value, output ready);
endinterface

interface plt_res_if;
    import plt_pkg::*;
    logic       valid;
    logic       ready;
    t_val       x_out;
    t_val       y_out;
    t_val       heading_out;
    t_val       curvature_out;
    t_val       width_out;
    logic [9:0] segment_index;
    logic [2:0] status;

    modport source (output valid, x_out, y_out, heading_out, curvature_out, width_out,
                    segment_index, status, input ready);
    modport sink (input valid, x_out, y_out, heading_out, curvature_out, width_out,
                  segment_index, status, output ready);
endinterface

>>> rtl/plt_div.sv
// bit-serial restoring divider for slopes: (dv * 2^FRAC_BITS) / ds, toward zero
// depends on plt_pkg
module plt_div #(
    parameter int FRAC_BITS = plt_pkg::DEF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  plt_pkg::t_div_req  i_req,
    output logic               o_done,
    output logic signed [63:0] o_quot
);
    import plt_pkg::*;

    localparam int NUMW = 33 + FRAC_BITS;
    localparam int CNTW = $clog2(NUMW + 1);

    logic            r_busy, r_done, r_neg;
    logic [CNTW-1:0] r_cnt;
    logic [NUMW-1:0] r_num;
    logic [31:0]     r_rem, r_den;
    logic [32:0]     mag, rem_sh, rem_sub;
    logic            ge;
    logic [63:0]     q64;

    assign mag     = i_req.dv[32] ? 33'(-i_req.dv) : 33'(i_req.dv);
    assign rem_sh  = {r_rem, r_num[NUMW-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign q64     = 64'(r_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(NUMW);
                r_num  <= {mag, {FRAC_BITS{1'b0}}};
                r_rem  <= '0;
                r_den  <= i_req.ds;
                r_neg  <= i_req.dv[32];
            end else if (r_busy) begin
                r_rem <= ge ? rem_sub[31:0] : rem_sh[31:0];
                r_num <= {r_num[NUMW-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(q64) : $signed(q64);

endmodule

>>> rtl/plt_mul.sv
// shift-add multiplier for slope * distance, scaled down and capped at 2^40
// depends on plt_pkg
module plt_mul #(
    parameter int FRAC_BITS = plt_pkg::DEF_FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  plt_pkg::t_mul_req                i_req,
    output logic                             o_done,
    output logic signed [plt_pkg::TERM_W-1:0] o_term
);
    import plt_pkg::*;

    localparam logic [96:0] CAP = 97'd1 << 40;

    logic        r_busy, r_done, r_neg;
    logic [5:0]  r_cnt;
    logic [63:0] r_a;
    logic [96:0] r_p, m_full;
    logic [64:0] sum;
    logic [40:0] m;

    assign sum    = {1'b0, r_p[96:33]} + (r_p[0] ? {1'b0, r_a} : 65'd0);
    assign m_full = r_p >> FRAC_BITS;
    assign m      = (m_full > CAP) ? CAP[40:0] : m_full[40:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd33;
                r_a    <= i_req.slope[63] ? 64'(-i_req.slope) : 64'(i_req.slope);
                r_p    <= {64'd0, (i_req.span[32] ? 33'(-i_req.span) : 33'(i_req.span))};
                r_neg  <= i_req.slope[63] ^ i_req.span[32];
            end else if (r_busy) begin
                r_p   <= {sum, r_p[32:1]};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_term = r_neg ? -$signed({1'b0, m}) : $signed({1'b0, m});

endmodule

>>> rtl/track_piecewise_linear_table.sv
// Piecewise linear track table, one word at a time. An append's time is set by the
// bit-serial slope divider (Q16.16 at the default FRAC_BITS) run once per channel;
// a query's time is set by the binary search over the single breakpoint read port
// and the 33-step multiplier run once per channel. The input is not ready while a
// word is in work; a finished result sits in an output register until taken. No
// clearing pass is needed after reset.
// depends on plt_pkg, plt_stream_if, plt_div, plt_mul
module track_piecewise_linear_table #(
    parameter int MAX_POINTS = plt_pkg::DEF_MAX_POINTS,
    parameter int FRAC_BITS  = plt_pkg::DEF_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    plt_pt_if.sink      i_pt,
    plt_res_if.source   o_res
);
    import plt_pkg::*;

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int SAW = $clog2(MAX_POINTS * NUM_CH);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_APP  = 5'd1;
    localparam logic [4:0] S_ACHK = 5'd2;
    localparam logic [4:0] S_ADST = 5'd3;
    localparam logic [4:0] S_ADIV = 5'd4;
    localparam logic [4:0] S_QRD0 = 5'd5;
    localparam logic [4:0] S_QCK0 = 5'd6;
    localparam logic [4:0] S_QCKL = 5'd7;
    localparam logic [4:0] S_QBS  = 5'd8;
    localparam logic [4:0] S_QBSC = 5'd9;
    localparam logic [4:0] S_QSEG = 5'd10;
    localparam logic [4:0] S_QD   = 5'd11;
    localparam logic [4:0] S_QMST = 5'd12;
    localparam logic [4:0] S_QMUL = 5'd13;
    localparam logic [4:0] S_FIN  = 5'd14;

    // storage
    logic [31:0] bp_mem [MAX_POINTS];
    t_vals       val_mem [MAX_POINTS];
    logic [63:0] sl_mem [MAX_POINTS*NUM_CH];

    logic [4:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [1:0]    r_kind;
    t_val          r_s, r_w;
    t_vals         r_vals, r_res, n_res;
    logic [2:0]    r_ch, n_ch;
    logic [2:0]    r_st, n_st;
    logic [AW-1:0] r_seg, n_seg, r_lo, n_lo, r_hi, n_hi, mid;
    logic signed [32:0] r_d, n_d;

    logic signed [31:0] r_bp_q;
    t_vals              r_val_q;
    logic [63:0]        r_sl_q;

    logic           rd_en, sl_rd_en, bp_we, sl_we;
    logic [AW-1:0]  rd_addr, wr_addr;
    logic [SAW-1:0] sl_raddr, sl_waddr;

    logic        r_ovalid, n_ovalid;
    t_vals       r_ores;
    logic [9:0]  r_oseg;
    logic [2:0]  r_ost;
    logic        load_out;
    logic [AW+9:0] seg_ext;

    t_div_req div_req;
    logic     div_done;
    logic signed [63:0] div_quot;
    t_mul_req mul_req;
    logic     mul_done;
    logic signed [TERM_W-1:0] mul_term;
    logic signed [42:0] v43;
    t_val     v_sat;
    logic     full, accept;

    plt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req),
        .o_done(div_done), .o_quot(div_quot)
    );

    plt_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mul_req),
        .o_done(mul_done), .o_term(mul_term)
    );

    assign accept = i_pt.valid && i_pt.ready;
    assign full   = r_cnt >= CW'(MAX_POINTS);
    assign mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign wr_addr = r_cnt[AW-1:0];
    assign sl_waddr = SAW'((int'(r_cnt) - 1) * NUM_CH + int'(r_ch));
    assign load_out = (r_state == S_FIN) && (!r_ovalid || o_res.ready);

    // value plus term, saturated to 32 bits
    assign v43   = 43'($signed(r_val_q[r_ch])) + 43'(mul_term);
    assign v_sat = (v43[42:31] == {12{v43[42]}}) ? v43[31:0]
                 : (v43[42] ? 32'sh8000_0000 : 32'sh7fff_ffff);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_res    = r_res;
        n_ch     = r_ch;
        n_st     = r_st;
        n_seg    = r_seg;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_d      = r_d;
        rd_en    = 1'b0;
        rd_addr  = '0;
        sl_rd_en = 1'b0;
        sl_raddr = '0;
        bp_we    = 1'b0;
        sl_we    = 1'b0;
        div_req  = '0;
        mul_req  = '0;
        div_req.dv = 33'($signed(r_vals[r_ch])) - 33'($signed(r_val_q[r_ch]));
        div_req.ds = 32'(33'(r_s) - 33'(r_bp_q));
        mul_req.slope = $signed(r_sl_q);
        mul_req.span  = r_d;
        n_ovalid = o_res.ready ? 1'b0 : r_ovalid;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res = '0;
                    n_st  = ST_OK;
                    n_seg = '0;
                    n_ch  = '0;
                    case (i_pt.kind)
                        K_APPEND: n_state = S_APP;
                        K_QUERY:  n_state = S_QRD0;
                        K_CLEAR: begin
                            n_cnt   = '0;
                            n_state = S_FIN;
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_APP: begin
                if (full) begin
                    n_st    = ST_FULL;
                    n_state = S_FIN;
                end else if (r_cnt == '0) begin
                    if (r_w <= 0) begin
                        n_st = ST_WIDTH;
                    end else begin
                        bp_we = 1'b1;
                        n_cnt = CW'(1);
                    end
                    n_state = S_FIN;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_cnt - 1'b1);
                    n_state = S_ACHK;
                end
            end
            S_ACHK: begin
                if (r_s <= r_bp_q) begin
                    n_st    = ST_NONMONO;
                    n_state = S_FIN;
                end else if (r_w <= 0) begin
                    n_st    = ST_WIDTH;
                    n_state = S_FIN;
                end else begin
                    bp_we   = 1'b1;
                    n_seg   = r_cnt[AW-1:0];
                    n_state = S_ADST;
                end
            end
            S_ADST: begin
                div_req.start = 1'b1;
                n_state = S_ADIV;
            end
            S_ADIV: begin
                if (div_done) begin
                    sl_we = 1'b1;
                    if (r_ch == 3'(NUM_CH - 1)) begin
                        n_cnt   = r_cnt + 1'b1;
                        n_state = S_FIN;
                    end else begin
                        n_ch    = r_ch + 1'b1;
                        n_state = S_ADST;
                    end
                end
            end
            S_QRD0: begin
                if (r_cnt < CW'(2)) begin
                    n_st    = ST_FEW;
                    n_state = S_FIN;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_QCK0;
                end
            end
            S_QCK0: begin
                if (r_s < r_bp_q) begin
                    n_st    = ST_BELOW;
                    n_state = S_QSEG;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_cnt - 1'b1);
                    n_state = S_QCKL;
                end
            end
            S_QCKL: begin
                if (r_s >= r_bp_q) begin
                    n_seg   = AW'(r_cnt - CW'(2));
                    n_st    = (r_s > r_bp_q) ? ST_ABOVE : ST_OK;
                    n_state = S_QSEG;
                end else begin
                    n_lo    = '0;
                    n_hi    = AW'(r_cnt - 1'b1);
                    n_state = S_QBS;
                end
            end
            S_QBS: begin
                if ((r_hi - r_lo) > AW'(1)) begin
                    rd_en   = 1'b1;
                    rd_addr = mid;
                    n_state = S_QBSC;
                end else begin
                    n_seg   = r_lo;
                    n_state = S_QSEG;
                end
            end
            S_QBSC: begin
                // bp_q holds the breakpoint at mid
                if (r_bp_q <= r_s) n_lo = mid;
                else               n_hi = mid;
                n_state = S_QBS;
            end
            S_QSEG: begin
                rd_en   = 1'b1;
                rd_addr = r_seg;
                n_state = S_QD;
            end
            S_QD: begin
                n_d      = 33'(r_s) - 33'(r_bp_q);
                sl_rd_en = 1'b1;
                sl_raddr = SAW'(int'(r_seg) * NUM_CH);
                n_state  = S_QMST;
            end
            S_QMST: begin
                mul_req.start = 1'b1;
                n_state = S_QMUL;
            end
            S_QMUL: begin
                if (mul_done) begin
                    n_res[r_ch] = v_sat;
                    if (r_ch == 3'(NUM_CH - 1)) begin
                        n_state = S_FIN;
                    end else begin
                        n_ch     = r_ch + 1'b1;
                        sl_rd_en = 1'b1;
                        sl_raddr = SAW'(int'(r_seg) * NUM_CH + int'(r_ch) + 1);
                        n_state  = S_QMST;
                    end
                end
            end
            S_FIN: begin
                if (load_out) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_pt.kind;
            r_s    <= i_pt.position;
            r_w    <= i_pt.width_value;
            r_vals <= {i_pt.width_value, i_pt.curvature_value, i_pt.heading_value,
                       i_pt.y_value, i_pt.x_value};
        end
        r_res <= n_res;
        r_ch  <= n_ch;
        r_st  <= n_st;
        r_seg <= n_seg;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_d   <= n_d;
        if (load_out) begin
            r_ores <= r_res;
            r_oseg <= (r_kind == K_APPEND && r_st != ST_OK) ? 10'd0 : seg_ext[9:0];
            r_ost  <= r_st;
        end
    end

    assign seg_ext = {10'd0, r_seg};

    // memories: one write and one registered read per cycle each
    always_ff @(posedge i_clk) begin
        if (bp_we) begin
            bp_mem[wr_addr]  <= r_s;
            val_mem[wr_addr] <= r_vals;
        end
        if (rd_en) begin
            r_bp_q  <= bp_mem[rd_addr];
            r_val_q <= val_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sl_we) sl_mem[sl_waddr] <= div_quot;
        if (sl_rd_en) r_sl_q <= sl_mem[sl_raddr];
    end

    assign i_pt.ready          = (r_state == S_IDLE);
    assign o_res.valid         = r_ovalid;
    assign o_res.x_out         = r_ores[0];
    assign o_res.y_out         = r_ores[1];
    assign o_res.heading_out   = r_ores[2];
    assign o_res.curvature_out = r_ores[3];
    assign o_res.width_out     = r_ores[4];
    assign o_res.segment_index = r_oseg;
    assign o_res.status        = r_ost;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_POINTS))
        else $error("point count beyond table depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_pt.ready)
        else $error("input ready right after a word was taken");

    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> o_res.valid && r_state == S_IDLE)
        else $error("finished word not presented");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> r_state == S_ADST && r_ch < 3'(NUM_CH))
        else $error("divider started outside append");

endmodule

>>> tb/tb_plt_checker.sv
// checker for the piecewise linear track table: watches the breakpoint/query and result
// channels, predicts each result word and compares it field by field
// depends on plt_pkg and plt_stream_if
`timescale 1ns / 100ps
module tb_plt_checker
    import plt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    plt_pt_if      pt,
    plt_res_if     res,
    output int     o_fail_count,
    output int     o_pending
);

    localparam int MAXP = DEF_MAX_POINTS;
    localparam int FB   = DEF_FRAC_BITS;

    typedef struct {
        logic signed [31:0] ch [NUM_CH];
        logic [9:0]         seg;
        logic [2:0]         st;
    } t_track_result;

    int unsigned             point_count;
    longint                  bp_s    [MAXP];
    longint                  bp_val  [MAXP][NUM_CH];
    longint                  bp_slope[MAXP][NUM_CH];
    t_track_result           expected_results[$];

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // exact product, truncated toward zero, magnitude capped at 2^40
    function automatic longint slope_term(longint slope, longint d);
        logic [63:0]  a;
        logic [63:0]  b;
        logic [127:0] p;
        logic [127:0] m;
        logic [127:0] cap;
        a   = slope < 0 ? -slope : slope;
        b   = d < 0 ? -d : d;
        p   = {64'd0, a} * {64'd0, b};
        m   = p >> FB;
        cap = 128'd1 << 40;
        if (m > cap) m = cap;
        return ((slope < 0) != (d < 0)) ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic t_track_result track_predict(logic [1:0] kind, longint s,
                                                    longint vals[NUM_CH]);
        t_track_result r;
        int unsigned   n;
        int unsigned   seg;
        int unsigned   lo;
        int unsigned   hi;
        int unsigned   mid;
        foreach (r.ch[c]) r.ch[c] = '0;
        r.seg = '0;
        r.st  = ST_OK;
        n = point_count;
        if (kind == K_APPEND) begin
            if (n >= MAXP) r.st = ST_FULL;
            else if (n > 0 && s <= bp_s[n-1]) r.st = ST_NONMONO;
            else if (vals[NUM_CH-1] <= 0) r.st = ST_WIDTH;
            else begin
                bp_s[n] = s;
                for (int c = 0; c < NUM_CH; c++) begin
                    bp_val[n][c] = vals[c];
                    if (n > 0)
                        bp_slope[n-1][c] = ((vals[c] - bp_val[n-1][c]) * (64'sd1 <<< FB))
                                           / (s - bp_s[n-1]);
                end
                point_count = n + 1;
                r.seg = n[9:0];
            end
        end else if (kind == K_QUERY) begin
            if (n < 2) r.st = ST_FEW;
            else begin
                if (s < bp_s[0]) begin
                    seg = 0;
                    r.st = ST_BELOW;
                end else if (s >= bp_s[n-1]) begin
                    seg = n - 2;
                    if (s > bp_s[n-1]) r.st = ST_ABOVE;
                end else begin
                    lo = 0;
                    hi = n - 1;
                    while (hi - lo > 1) begin
                        mid = lo + (hi - lo) / 2;
                        if (bp_s[mid] <= s) lo = mid; else hi = mid;
                    end
                    seg = lo;
                end
                for (int c = 0; c < NUM_CH; c++)
                    r.ch[c] = 32'(sat_word(bp_val[seg][c]
                                           + slope_term(bp_slope[seg][c], s - bp_s[seg])));
                r.seg = seg[9:0];
            end
        end else if (kind == K_CLEAR) begin
            point_count = 0;
        end
        return r;
    endfunction

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_track_result e;
        longint        vals[NUM_CH];
        if (!i_rst_n) begin
            point_count = 0;
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            if (pt.valid && pt.ready) begin
                vals[0] = pt.x_value;
                vals[1] = pt.y_value;
                vals[2] = pt.heading_value;
                vals[3] = pt.curvature_value;
                vals[4] = pt.width_value;
                expected_results.push_back(track_predict(pt.kind, pt.position, vals));
            end
            if (res.valid && res.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result word with nothing expected");
                    o_fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    check_field("x_out", e.ch[0], res.x_out);
                    check_field("y_out", e.ch[1], res.y_out);
                    check_field("heading_out", e.ch[2], res.heading_out);
                    check_field("curvature_out", e.ch[3], res.curvature_out);
                    check_field("width_out", e.ch[4], res.width_out);
                    check_field("segment_index", e.seg, res.segment_index);
                    check_field("status", e.st, res.status);
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

>>> tb/tb_top.sv
// stimulus and verdict for the piecewise linear track table
// depends on plt_pkg, plt_stream_if, the table top level and tb_plt_checker
`timescale 1ns / 100ps
module tb_top;
    import plt_pkg::*;

    localparam int IDLE_PCT   = 31;
    localparam int N_RANDOM   = 400;
    localparam int STALL_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   quiet_cycles;
    bit   calm;
    bit   stim_done;
    longint last_s;

    plt_pt_if  pt_ch();
    plt_res_if res_ch();

    track_piecewise_linear_table dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pt   (pt_ch.sink),
        .o_res  (res_ch.source)
    );

    tb_plt_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .pt          (pt_ch),
        .res         (res_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        pt_ch.valid = 1'b0;
        pt_ch.kind = K_CLEAR;
        pt_ch.position = '0;
        pt_ch.x_value = '0;
        pt_ch.y_value = '0;
        pt_ch.heading_value = '0;
        pt_ch.curvature_value = '0;
        pt_ch.width_value = '0;
        res_ch.ready = 1'b0;
    end

    // receiver stalls at random except during the calm stretch
    always @(posedge i_clk)
        res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

    task automatic send_word(logic [1:0] kind, logic [31:0] s, logic [31:0] x,
                             logic [31:0] y, logic [31:0] h, logic [31:0] k,
                             logic [31:0] w);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            pt_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_ch.valid <= 1'b1;
        pt_ch.kind <= kind;
        pt_ch.position <= s;
        pt_ch.x_value <= x;
        pt_ch.y_value <= y;
        pt_ch.heading_value <= h;
        pt_ch.curvature_value <= k;
        pt_ch.width_value <= w;
        do @(posedge i_clk); while (!pt_ch.ready);
    endtask

    task automatic append_rand(logic [31:0] s);
        send_word(K_APPEND, s, $urandom, $urandom, $urandom, $urandom,
                  $urandom_range(32'h7fff_ffff, 1));
    endtask

    task automatic build_track(int n);
        longint s;
        s = $signed($urandom_range(32'h0010_0000)) - 64'sd1048576;
        send_word(K_CLEAR, 0, 0, 0, 0, 0, 1);
        for (int i = 0; i < n; i++) begin
            if (s > 64'sd2147483647) break;
            append_rand(s[31:0]);
            last_s = s;
            s += ($urandom_range(3) == 0) ? $urandom_range(32'h00ff_ffff, 1)
                                          : $urandom_range(32'h0004_0000, 1);
        end
    endtask

    initial begin
        logic [31:0] q;
        calm = 1'b0;
        stim_done = 1'b0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: empty and single point queries, rejects, extremes
        send_word(K_QUERY, 0, 0, 0, 0, 0, 0);
        send_word(K_APPEND, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                  32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_word(K_QUERY, 0, 0, 0, 0, 0, 0);
        send_word(K_APPEND, 32'h8000_0000, 0, 0, 0, 0, 1);
        send_word(K_APPEND, 32'h8000_0001, 0, 0, 0, 0, 0);
        send_word(K_APPEND, 32'h8000_0001, 0, 0, 0, 0, 32'h8000_0000);
        send_word(K_APPEND, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                  32'h8000_0000, 32'h7fff_ffff, 1);
        send_word(K_QUERY, 32'h8000_0000, 0, 0, 0, 0, 0);
        send_word(K_QUERY, 32'h7fff_ffff, 0, 0, 0, 0, 0);
        send_word(K_QUERY, 0, 0, 0, 0, 0, 0);
        send_word(K_APPEND, 32'h7fff_ffff, 0, 0, 0, 0, 1);
        send_word(K_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                  32'hffff_ffff, 32'hffff_ffff);
        // steep slopes to reach saturation and the term cap
        send_word(K_CLEAR, 0, 0, 0, 0, 0, 0);
        send_word(K_APPEND, 0, 0, 0, 0, 0, 1);
        send_word(K_APPEND, 1, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0100,
                  32'hffff_ff00, 32'h7fff_ffff);
        send_word(K_QUERY, 32'h8000_0000, 0, 0, 0, 0, 0);
        send_word(K_QUERY, 32'h7fff_ffff, 0, 0, 0, 0, 0);
        send_word(K_QUERY, 1, 0, 0, 0, 0, 0);
        // fill the table completely once, then overflow
        calm = 1'b1;
        send_word(K_CLEAR, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < DEF_MAX_POINTS; i++)
            append_rand(32'(i * 4096 - 2000000));
        append_rand(32'h7fff_0000);
        send_word(K_QUERY, 32'(100 * 4096 + 7), 0, 0, 0, 0, 0);
        calm = 1'b0;
        // random: small tracks with random content, mostly queries
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 60 == 0) build_track($urandom_range(12, 2));
            case ($urandom_range(19))
                0: append_rand($urandom);
                1: send_word(2'($urandom_range(3)), $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom);
                2: begin
                    last_s += $urandom_range(32'h0002_0000, 1);
                    if (last_s <= 64'sd2147483647) append_rand(last_s[31:0]);
                end
                3: send_word(K_QUERY, $urandom, 0, 0, 0, 0, 0);
                default: begin
                    q = last_s[31:0] - $urandom_range(32'h0300_0000)
                        + $urandom_range(32'h0008_0000);
                    send_word(K_QUERY, q, $urandom, $urandom, $urandom, $urandom,
                              $urandom);
                end
            endcase
            calm = (i >= 150 && i < 250);
        end
        pt_ch.valid <= 1'b0;
        stim_done <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pt_ch.valid && pt_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (i_rst_n === 1'b1);
        fork
            begin
                wait (stim_done && pending == 0);
                repeat (400) @(posedge i_clk);
                if (fail_count == 0)
                    $display("tb_top: PASS");
                else
                    $display("tb_top: FAIL");
            end
            begin
                wait (quiet_cycles >= STALL_LIMIT);
                $display("tb_top: FAIL");
            end
        join_any
        $finish;
    end

endmodule

>>> files.f
rtl/plt_pkg.sv
rtl/plt_stream_if.sv
rtl/plt_div.sv
rtl/plt_mul.sv
rtl/track_piecewise_linear_table.sv
tb/tb_plt_checker.sv
tb/tb_top.sv
